FILE: hw/rtl/bcrm_pkg.sv
package bcrm_pkg;

  localparam int unsigned FLAG_COUNT = 8;
  localparam int unsigned SIGN_BIT   = 15;

  // Opcodes.
  localparam logic [7:0] OP_END  = 8'd0;
  localparam logic [7:0] OP_JMP  = 8'd1;
  localparam logic [7:0] OP_BFS  = 8'd2;
  localparam logic [7:0] OP_BFC  = 8'd3;
  localparam logic [7:0] OP_ADD  = 8'd4;
  localparam logic [7:0] OP_SUB  = 8'd5;
  localparam logic [7:0] OP_MUL  = 8'd6;
  localparam logic [7:0] OP_DIV  = 8'd7;
  localparam logic [7:0] OP_REM  = 8'd8;
  localparam logic [7:0] OP_LDI  = 8'd9;
  localparam logic [7:0] OP_MOV  = 8'd10;
  localparam logic [7:0] OP_LDM  = 8'd11;
  localparam logic [7:0] OP_STM  = 8'd12;
  localparam logic [7:0] OP_CEQ  = 8'd13;
  localparam logic [7:0] OP_CLT  = 8'd14;
  localparam logic [7:0] OP_CGT  = 8'd15;
  localparam logic [7:0] OP_CLE  = 8'd16;
  localparam logic [7:0] OP_CGE  = 8'd17;
  localparam logic [7:0] OP_PUT  = 8'd18;

  // Error codes.
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_REG  = 3'd1;
  localparam logic [2:0] ERR_FLAG = 3'd2;
  localparam logic [2:0] ERR_EOM  = 3'd3;
  localparam logic [2:0] ERR_OP   = 3'd4;
  localparam logic [2:0] ERR_DIV0 = 3'd5;

  // Flag bit positions.
  localparam logic [7:0] FLG_ZERO = 8'h01;
  localparam logic [7:0] FLG_POS  = 8'h02;
  localparam logic [7:0] FLG_NEG  = 8'h04;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_FETCH  = 9'b000000010,
    ST_DECODE = 9'b000000100,
    ST_MEMRD  = 9'b000001000,
    ST_REGRD  = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_MUL    = 9'b001000000,
    ST_WB     = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  // Number of operand bytes after the opcode.
  function automatic logic [1:0] operand_bytes(input logic [7:0] op);
    logic [1:0] n;
    n = 2'd2;
    case (op)
      OP_END:                  n = 2'd0;
      OP_BFS, OP_BFC, OP_LDI,
      OP_LDM, OP_STM:          n = 2'd3;
      default:                 n = 2'd2;
    endcase
    return n;
  endfunction

  // Flags after a value is written: exactly one of zero, negative, positive.
  function automatic logic [7:0] sign_flags(input logic [15:0] v);
    logic [7:0] f;
    if (v == 16'd0) f = FLG_ZERO;
    else if (v[SIGN_BIT]) f = FLG_NEG;
    else f = FLG_POS;
    return f;
  endfunction

endpackage

FILE: hw/rtl/bcrm_ram.sv
module bcrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bcrm_divider.sv
module bcrm_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);

  logic [15:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] shifted;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[15]};
    trial    = shifted - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = 16'd0;
      dvs_nxt  = divisor;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = shifted[15:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/byte_code_register_machine.sv
// out_tvalid rises after ST_OUT registers the result word. A load word or a step
// on a stopped machine reaches ST_OUT from ST_IDLE, an end from ST_DECODE; other
// steps pass ST_FETCH per operand byte, ST_REGRD, then ST_MEMRD for a memory load,
// ST_MUL or ST_DIV, and ST_WB for a register write; an error ends the step there.
// A new word is taken in the cycle after a result is registered, also while it waits.
// Reset clears pc, registers, flags, halt, error and length; memory is undefined.
module byte_code_register_machine #(
  parameter int MEMORY_BYTES   = 65536,
  parameter int REGISTER_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,     // program_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // load_address[15:0], load_data[23:16]
  input  logic        in_tuser,      // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata      // next_pc[16:0], halted[17], error_code[20:18],
                                     // put_valid[21], put_format[23:22],
                                     // put_value[39:24], flag_bits[47:40]
);

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int RW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  bcrm_pkg::state_t state_r, state_nxt;

  logic [16:0] plen_r;
  logic [16:0] pc_r, pc_nxt;
  logic [15:0] regs_r [REGISTER_COUNT];
  logic [7:0]  flags_r, flags_nxt;
  logic        stop_r, stop_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  b1_r, b1_nxt, b2_r, b2_nxt, b3_r, b3_nxt;
  logic [1:0]  idx_r, idx_nxt;    // bytes fetched so far, opcode excluded
  logic [15:0] x_r, x_nxt, y_r, y_nxt, res_r, res_nxt;
  logic [31:0] prod_r;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_q, div_rem;
  logic        ovalid_r, ovalid_nxt;
  logic [47:0] odata_r, odata_nxt;
  logic        pv_r, pv_nxt;
  logic [1:0]  pf_r, pf_nxt;
  logic [15:0] pval_r, pval_nxt;

  // Register file writes.
  logic        rwe;
  logic [RW-1:0] rwa;
  logic [15:0] rwd;

  // Memory port.
  logic          mwe;
  logic [AW-1:0] mwa, mra;
  logic [7:0]    mwd, mrd;

  bcrm_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
    .clk(clk), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd)
  );

  bcrm_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(x_r), .divisor(y_r),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  // Register index checks; rc holds register counts up to 511.
  logic [8:0] rc;
  logic       ra_ok, rb_ok;
  assign rc = 9'(REGISTER_COUNT);
  logic [7:0] rega, regb;
  logic [15:0] a16_ldm;
  logic [15:0] a16_stm;

  always_comb begin
    rega = (op_r == bcrm_pkg::OP_STM) ? b3_r : b1_r;
    regb = b2_r;
    ra_ok = {1'b0, rega} < rc;
    rb_ok = {1'b0, regb} < rc;
    a16_ldm = {b3_r, b2_r};
    a16_stm = {b2_r, b1_r};
  end

  logic fetch_ok;
  assign fetch_ok = (pc_r < plen_r) && (pc_r < 17'(MEMORY_BYTES));

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    flags_nxt = flags_r;
    stop_nxt  = stop_r;
    err_nxt   = err_r;
    op_nxt    = op_r;
    b1_nxt    = b1_r;
    b2_nxt    = b2_r;
    b3_nxt    = b3_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    res_nxt   = res_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt = odata_r;
    pv_nxt    = pv_r;
    pf_nxt    = pf_r;
    pval_nxt  = pval_r;
    rwe = 1'b0;
    rwa = rega[RW-1:0];
    rwd = res_r;
    mwe = 1'b0;
    mwa = in_tdata[AW-1:0];
    mwd = in_tdata[23:16];
    mra = pc_r[AW-1:0];
    div_start = 1'b0;
    in_tready = (state_r == bcrm_pkg::ST_IDLE);

    case (state_r)
      bcrm_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          pv_nxt   = 1'b0;
          pf_nxt   = 2'd0;
          pval_nxt = 16'd0;
          if (!in_tuser) begin
            mwe = 1'b1;
            state_nxt = bcrm_pkg::ST_OUT;
          end else if (stop_r) begin
            state_nxt = bcrm_pkg::ST_OUT;
          end else begin
            idx_nxt = 2'd0;
            state_nxt = bcrm_pkg::ST_DECODE;
            if (fetch_ok) begin
              pc_nxt = pc_r + 17'd1;
            end else begin
              stop_nxt = 1'b1;
              err_nxt = bcrm_pkg::ERR_EOM;
              state_nxt = bcrm_pkg::ST_OUT;
            end
          end
        end
      end
      // Opcode byte arrives.
      bcrm_pkg::ST_DECODE: begin
        op_nxt = mrd;
        if (mrd == bcrm_pkg::OP_END) begin
          stop_nxt = 1'b1;
          state_nxt = bcrm_pkg::ST_OUT;
        end else if (mrd > bcrm_pkg::OP_PUT) begin
          stop_nxt = 1'b1;
          err_nxt = bcrm_pkg::ERR_OP;
          state_nxt = bcrm_pkg::ST_OUT;
        end else if (fetch_ok) begin
          pc_nxt = pc_r + 17'd1;
          state_nxt = bcrm_pkg::ST_FETCH;
        end else begin
          stop_nxt = 1'b1;
          err_nxt = bcrm_pkg::ERR_EOM;
          state_nxt = bcrm_pkg::ST_OUT;
        end
      end
      // Operand bytes, one per cycle.
      bcrm_pkg::ST_FETCH: begin
        case (idx_r)
          2'd0:    b1_nxt = mrd;
          2'd1:    b2_nxt = mrd;
          default: b3_nxt = mrd;
        endcase
        idx_nxt = idx_r + 2'd1;
        if (idx_r + 2'd1 == bcrm_pkg::operand_bytes(op_r)) begin
          state_nxt = bcrm_pkg::ST_REGRD;
        end else if (fetch_ok) begin
          pc_nxt = pc_r + 17'd1;
        end else begin
          stop_nxt = 1'b1;
          err_nxt = bcrm_pkg::ERR_EOM;
          state_nxt = bcrm_pkg::ST_OUT;
        end
      end
      // Check operands and execute.
      bcrm_pkg::ST_REGRD: begin
        state_nxt = bcrm_pkg::ST_OUT;
        x_nxt = regs_r[rega[RW-1:0]];
        y_nxt = regs_r[regb[RW-1:0]];
        case (op_r)
          bcrm_pkg::OP_JMP: pc_nxt = {1'b0, b2_r, b1_r};
          bcrm_pkg::OP_BFS, bcrm_pkg::OP_BFC: begin
            if (b1_r >= 8'(bcrm_pkg::FLAG_COUNT)) begin
              stop_nxt = 1'b1;
              err_nxt = bcrm_pkg::ERR_FLAG;
            end else if (flags_r[b1_r[2:0]] == (op_r == bcrm_pkg::OP_BFS)) begin
              pc_nxt = {1'b0, b3_r, b2_r};
            end
          end
          bcrm_pkg::OP_LDI: begin
            if (!ra_ok) begin
              stop_nxt = 1'b1;
              err_nxt = bcrm_pkg::ERR_REG;
            end else begin
              res_nxt = {b3_r, b2_r};
              state_nxt = bcrm_pkg::ST_WB;
            end
          end
          bcrm_pkg::OP_LDM: begin
            if (!ra_ok) begin
              stop_nxt = 1'b1;
              err_nxt = bcrm_pkg::ERR_REG;
            end else begin
              mra = a16_ldm[AW-1:0];
              state_nxt = bcrm_pkg::ST_MEMRD;
            end
          end
          bcrm_pkg::OP_STM: begin
            if (!ra_ok) begin
              stop_nxt = 1'b1;
              err_nxt = bcrm_pkg::ERR_REG;
            end else begin
              mwe = 1'b1;
              mwa = a16_stm[AW-1:0];
              mwd = regs_r[rega[RW-1:0]][7:0];
              flags_nxt = bcrm_pkg::sign_flags(regs_r[rega[RW-1:0]]);
            end
          end
          bcrm_pkg::OP_PUT: begin
            if (!ra_ok) begin
              stop_nxt = 1'b1;
              err_nxt = bcrm_pkg::ERR_REG;
            end else if (b2_r <= 8'd3) begin
              pv_nxt = 1'b1;
              pf_nxt = b2_r[1:0];
              pval_nxt = regs_r[rega[RW-1:0]];
            end
          end
          default: begin
            if (!ra_ok || !rb_ok) begin
              stop_nxt = 1'b1;
              err_nxt = bcrm_pkg::ERR_REG;
            end else begin
              state_nxt = bcrm_pkg::ST_WB;
              case (op_r)
                bcrm_pkg::OP_ADD: res_nxt = x_nxt + y_nxt;
                bcrm_pkg::OP_SUB: res_nxt = x_nxt - y_nxt;
                bcrm_pkg::OP_MOV: res_nxt = y_nxt;
                bcrm_pkg::OP_MUL: state_nxt = bcrm_pkg::ST_MUL;
                bcrm_pkg::OP_DIV, bcrm_pkg::OP_REM: begin
                  if (y_nxt == 16'd0) begin
                    stop_nxt = 1'b1;
                    err_nxt = bcrm_pkg::ERR_DIV0;
                    state_nxt = bcrm_pkg::ST_OUT;
                  end else begin
                    state_nxt = bcrm_pkg::ST_DIV;
                  end
                end
                default: begin
                  // Unsigned compares.
                  state_nxt = bcrm_pkg::ST_OUT;
                  flags_nxt = 8'd0;
                  case (op_r)
                    bcrm_pkg::OP_CEQ: flags_nxt[3] = x_nxt == y_nxt;
                    bcrm_pkg::OP_CLT: flags_nxt[4] = x_nxt < y_nxt;
                    bcrm_pkg::OP_CGT: flags_nxt[5] = x_nxt > y_nxt;
                    bcrm_pkg::OP_CLE: flags_nxt[6] = x_nxt <= y_nxt;
                    default:          flags_nxt[7] = x_nxt >= y_nxt;
                  endcase
                end
              endcase
            end
          end
        endcase
      end
      bcrm_pkg::ST_MEMRD: begin
        res_nxt = {8'd0, mrd};
        state_nxt = bcrm_pkg::ST_WB;
      end
      bcrm_pkg::ST_MUL: begin
        res_nxt = prod_r[15:0];
        state_nxt = bcrm_pkg::ST_WB;
      end
      bcrm_pkg::ST_DIV: begin
        if (div_done) begin
          res_nxt = (op_r == bcrm_pkg::OP_DIV) ? div_q : div_rem;
          state_nxt = bcrm_pkg::ST_WB;
        end
      end
      bcrm_pkg::ST_WB: begin
        rwe = 1'b1;
        flags_nxt = bcrm_pkg::sign_flags(res_r);
        state_nxt = bcrm_pkg::ST_OUT;
      end
      bcrm_pkg::ST_OUT: begin
        // The result register takes the word once its previous word has left.
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {flags_r, pval_r, pf_r, pv_r, err_r, stop_r, pc_r};
          state_nxt  = bcrm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bcrm_pkg::ST_IDLE;
    endcase

    if (state_nxt == bcrm_pkg::ST_DIV && state_r == bcrm_pkg::ST_REGRD) begin
      div_start = 1'b0;
    end
    if (state_r == bcrm_pkg::ST_DIV && !div_done && idx_r != 2'd0) begin
      div_start = 1'b0;
    end
    if (state_r == bcrm_pkg::ST_REGRD) begin
      idx_nxt = 2'd0;
    end
    if (state_r == bcrm_pkg::ST_DIV && idx_r == 2'd0) begin
      div_start = 1'b1;
      idx_nxt = 2'd1;
    end
  end

  // Divider is started in the cycle after operands are latched; its done flag
  // cannot fire in that same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bcrm_pkg::ST_IDLE;
      plen_r   <= 17'd0;
      pc_r     <= 17'd0;
      flags_r  <= 8'd0;
      stop_r   <= 1'b0;
      err_r    <= bcrm_pkg::ERR_NONE;
      ovalid_r <= 1'b0;
      idx_r    <= 2'd0;
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs_r[i] <= 16'd0;
      end
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        plen_r <= cfg_wdata;
      end
      pc_r     <= pc_nxt;
      flags_r  <= flags_nxt;
      stop_r   <= stop_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
      if (rwe) begin
        regs_r[rwa] <= rwd;
      end
    end
    op_r    <= op_nxt;
    b1_r    <= b1_nxt;
    b2_r    <= b2_nxt;
    b3_r    <= b3_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    res_r   <= res_nxt;
    prod_r  <= x_nxt * y_nxt;
    odata_r <= odata_nxt;
    pv_r    <= pv_nxt;
    pf_r    <= pf_nxt;
    pval_r  <= pval_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

FILE: sim/byte_code_register_machine_test.sv
module byte_code_register_machine_test;

  localparam int MEM_BYTES   = 65536;
  localparam int REG_COUNT   = 4;
  localparam int STALL_LIMIT = 3000;

  // One result word as it appears on out_tdata, top field first.
  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] value;
    logic [1:0]  fmt;
    logic        put;
    logic [2:0]  err;
    logic        halted;
    logic [16:0] pc;
  } machine_status_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [16:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // load_address[15:0], load_data[23:16]
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // next_pc, halted, error_code, put_valid, put_format,
                           // put_value, flag_bits

  byte_code_register_machine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow machine state.
  logic [7:0]  shadow_mem [0:MEM_BYTES-1];
  logic [16:0] shadow_pc;
  logic [16:0] shadow_len;
  logic [15:0] shadow_regs [0:REG_COUNT-1];
  logic [7:0]  shadow_flags;
  bit          shadow_halt;
  logic [2:0]  shadow_err;
  logic [15:0] written_addrs[$];

  machine_status_t pending_status[$];
  int  fail_count;
  bit  quiet;
  bit  rx_hold;
  int  rx_gap = 0;
  int  idle_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] value_flags(input logic [15:0] v);
    if (v == 16'd0) return bcrm_pkg::FLG_ZERO;
    if (v[15]) return bcrm_pkg::FLG_NEG;
    return bcrm_pkg::FLG_POS;
  endfunction

  function automatic void halt_with(input logic [2:0] code);
    shadow_err  = code;
    shadow_halt = 1'b1;
  endfunction

  // Program fetch, bounded by the program length and the memory size.
  function automatic bit fetch_byte(output logic [7:0] b);
    b = 8'd0;
    if (shadow_pc >= shadow_len || shadow_pc >= MEM_BYTES) begin
      halt_with(bcrm_pkg::ERR_EOM);
      return 1'b0;
    end
    b = shadow_mem[shadow_pc[15:0]];
    shadow_pc = shadow_pc + 17'd1;
    return 1'b1;
  endfunction

  function automatic bit reg_valid(input logic [7:0] r);
    if (r < REG_COUNT) return 1'b1;
    halt_with(bcrm_pkg::ERR_REG);
    return 1'b0;
  endfunction

  // Executes one accepted word on the shadow machine.
  function automatic machine_status_t execute_word(input logic kind, input logic [15:0] addr,
                                                   input logic [7:0] data);
    machine_status_t s;
    logic [7:0]  op, a8, b8, lo, hi;
    logic [15:0] x, y, r;
    bit          t;
    s = '0;
    if (!kind) begin
      shadow_mem[addr] = data;
      written_addrs.push_back(addr);
    end else if (!shadow_halt && fetch_byte(op)) begin
      case (op)
        bcrm_pkg::OP_END: shadow_halt = 1'b1;
        bcrm_pkg::OP_JMP: if (fetch_byte(lo) && fetch_byte(hi)) shadow_pc = {1'b0, hi, lo};
        bcrm_pkg::OP_BFS, bcrm_pkg::OP_BFC: begin
          if (fetch_byte(a8) && fetch_byte(lo) && fetch_byte(hi)) begin
            if (a8 >= bcrm_pkg::FLAG_COUNT) halt_with(bcrm_pkg::ERR_FLAG);
            else if (shadow_flags[a8[2:0]] == (op == bcrm_pkg::OP_BFS))
              shadow_pc = {1'b0, hi, lo};
          end
        end
        bcrm_pkg::OP_LDI, bcrm_pkg::OP_LDM: begin
          if (fetch_byte(a8) && fetch_byte(lo) && fetch_byte(hi) && reg_valid(a8)) begin
            r = (op == bcrm_pkg::OP_LDI) ? {hi, lo} : {8'd0, shadow_mem[{hi, lo}]};
            shadow_regs[a8[1:0]] = r;
            shadow_flags = value_flags(r);
          end
        end
        bcrm_pkg::OP_STM: begin
          if (fetch_byte(lo) && fetch_byte(hi) && fetch_byte(b8) && reg_valid(b8)) begin
            shadow_mem[{hi, lo}] = shadow_regs[b8[1:0]][7:0];
            written_addrs.push_back({hi, lo});
            shadow_flags = value_flags(shadow_regs[b8[1:0]]);
          end
        end
        bcrm_pkg::OP_PUT: begin
          if (fetch_byte(a8) && fetch_byte(b8) && reg_valid(a8) && b8 <= 8'd3) begin
            s.put   = 1'b1;
            s.fmt   = b8[1:0];
            s.value = shadow_regs[a8[1:0]];
          end
        end
        default: begin
          if (op > bcrm_pkg::OP_PUT) halt_with(bcrm_pkg::ERR_OP);
          else if (fetch_byte(a8) && fetch_byte(b8) && reg_valid(a8) && reg_valid(b8)) begin
            x = shadow_regs[a8[1:0]];
            y = shadow_regs[b8[1:0]];
            if (op >= bcrm_pkg::OP_CEQ) begin
              case (op)
                bcrm_pkg::OP_CEQ: t = (x == y);
                bcrm_pkg::OP_CLT: t = (x < y);
                bcrm_pkg::OP_CGT: t = (x > y);
                bcrm_pkg::OP_CLE: t = (x <= y);
                default:          t = (x >= y);
              endcase
              shadow_flags = t ? (8'd1 << (op - bcrm_pkg::OP_MOV)) : 8'd0;
            end else if ((op == bcrm_pkg::OP_DIV || op == bcrm_pkg::OP_REM) && y == 16'd0) begin
              halt_with(bcrm_pkg::ERR_DIV0);
            end else begin
              case (op)
                bcrm_pkg::OP_ADD: r = x + y;
                bcrm_pkg::OP_SUB: r = x - y;
                bcrm_pkg::OP_MUL: r = x * y;
                bcrm_pkg::OP_DIV: r = x / y;
                bcrm_pkg::OP_REM: r = x % y;
                default:          r = y;
              endcase
              shadow_regs[a8[1:0]] = r;
              shadow_flags = value_flags(r);
            end
          end
        end
      endcase
    end
    s.pc     = shadow_pc;
    s.halted = shadow_halt;
    s.err    = shadow_err;
    s.flags  = shadow_flags;
    return s;
  endfunction

  // Offers one word and waits for its handshake.
  task automatic send_word(input logic kind, input logic [15:0] addr, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {data, addr};
    do @(posedge clk); while (!in_tready);
    pending_status.push_back(execute_word(kind, addr, data));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // Loads four bytes at the pc, sometimes after one random load, then steps once.
  task automatic run_instr(input logic [7:0] c0, c1, c2, c3);
    logic [7:0] code [0:3];
    code = '{c0, c1, c2, c3};
    if ($urandom_range(0, 3) == 0) send_word(1'b0, 16'($urandom), 8'($urandom));
    for (int i = 0; i < 4; i++) send_word(1'b0, shadow_pc[15:0] + 16'(i), code[i]);
    send_word(1'b1, 16'($urandom), 8'($urandom));
  endtask

  task automatic run_random_instr();
    logic [7:0]  op, ra, rb, c1, c2, c3;
    logic [15:0] tgt, v;
    int          k;
    // Keep the pc clear of the program end.
    if (shadow_pc + 17'd8 > shadow_len) begin
      tgt = 16'($urandom_range(0, shadow_len - 8));
      run_instr(bcrm_pkg::OP_JMP, tgt[7:0], tgt[15:8], 8'($urandom));
      return;
    end
    op  = 8'($urandom_range(bcrm_pkg::OP_JMP, bcrm_pkg::OP_PUT));
    ra  = 8'($urandom_range(0, REG_COUNT - 1));
    rb  = 8'($urandom_range(0, REG_COUNT - 1));
    tgt = 16'($urandom_range(0, shadow_len - 8));
    c1 = ra;
    c2 = rb;
    c3 = 8'($urandom);
    if ((op == bcrm_pkg::OP_DIV || op == bcrm_pkg::OP_REM) && shadow_regs[rb[1:0]] == 16'd0)
      op = bcrm_pkg::OP_ADD;
    case (op)
      bcrm_pkg::OP_JMP: begin
        c1 = tgt[7:0];
        c2 = tgt[15:8];
      end
      bcrm_pkg::OP_BFS, bcrm_pkg::OP_BFC: begin
        c1 = 8'($urandom_range(0, bcrm_pkg::FLAG_COUNT - 1));
        c2 = tgt[7:0];
        c3 = tgt[15:8];
      end
      bcrm_pkg::OP_LDI: begin
        k = $urandom_range(0, 5);
        v = (k == 0) ? 16'h0000 : (k == 1) ? 16'h8000 : (k == 2) ? 16'hFFFF : 16'($urandom);
        c2 = v[7:0];
        c3 = v[15:8];
      end
      bcrm_pkg::OP_LDM: begin
        v  = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        c2 = v[7:0];
        c3 = v[15:8];
      end
      bcrm_pkg::OP_STM: begin
        v  = 16'($urandom);
        c1 = v[7:0];
        c2 = v[15:8];
        c3 = rb;
      end
      bcrm_pkg::OP_PUT: c2 = 8'($urandom_range(0, 7));
      default: ;
    endcase
    run_instr(op, c1, c2, c3);
  endtask

  // Length changes with nothing in flight, pc at zero unless halted or length < 4
  task automatic set_length(input logic [16:0] len);
    if (!shadow_halt && shadow_len >= 17'd4) run_instr(bcrm_pkg::OP_JMP, 8'd0, 8'd0, 8'd0);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_len = len;
  endtask

  task automatic check_field(input string name, input logic [16:0] expv, input logic [16:0] act);
    if (expv !== act) begin
      $error("%s: expected %0h, got %0h", name, expv, act);
      fail_count++;
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    machine_status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_status.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("next_pc", want.pc, got.pc);
        check_field("halted", want.halted, got.halted);
        check_field("error_code", want.err, got.err);
        check_field("put_valid", want.put, got.put);
        check_field("put_format", want.fmt, got.fmt);
        check_field("put_value", want.value, got.value);
        check_field("flag_bits", want.flags, got.flags);
      end
    end
  end

  // Receiver with random back-pressure.
  always @(negedge clk) begin
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25)
        rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("byte_code_register_machine_test: FAIL");
      $finish;
    end
  end

  // Loads are accepted while the program length is still zero.
  task automatic test_loads_at_reset();
    send_word(1'b0, 16'hFFFF, 8'hFF);
    send_word(1'b0, 16'h0000, 8'h00);
    send_word(1'b0, 16'h5AA5, 8'hA5);
    for (int i = 0; i < 6; i++) send_word(1'b0, 16'($urandom), 8'($urandom));
  endtask

  // Every opcode but OP_END at least once with edge values, and every put format.
  task automatic test_each_opcode();
    set_length(17'd65536);
    quiet = 1'b1;
    run_instr(bcrm_pkg::OP_LDI, 8'd0, 8'h00, 8'h00);
    run_instr(bcrm_pkg::OP_LDI, 8'd1, 8'hFF, 8'hFF);
    run_instr(bcrm_pkg::OP_LDI, 8'd2, 8'h00, 8'h80);
    run_instr(bcrm_pkg::OP_LDI, 8'd3, 8'h07, 8'h00);
    run_instr(bcrm_pkg::OP_ADD, 8'd1, 8'd3, 8'd0);
    run_instr(bcrm_pkg::OP_SUB, 8'd0, 8'd3, 8'd0);
    run_instr(bcrm_pkg::OP_MUL, 8'd2, 8'd3, 8'd0);
    run_instr(bcrm_pkg::OP_DIV, 8'd1, 8'd3, 8'd0);
    run_instr(bcrm_pkg::OP_REM, 8'd0, 8'd3, 8'd0);
    run_instr(bcrm_pkg::OP_MOV, 8'd1, 8'd2, 8'd0);
    run_instr(bcrm_pkg::OP_CEQ, 8'd1, 8'd2, 8'd0);
    run_instr(bcrm_pkg::OP_BFS, 8'd3, 8'h00, 8'h40);
    run_instr(bcrm_pkg::OP_CLT, 8'd3, 8'd2, 8'd0);
    run_instr(bcrm_pkg::OP_CGT, 8'd3, 8'd2, 8'd0);
    run_instr(bcrm_pkg::OP_BFC, 8'd7, 8'h10, 8'h20);
    run_instr(bcrm_pkg::OP_CLE, 8'd2, 8'd2, 8'd0);
    run_instr(bcrm_pkg::OP_CGE, 8'd0, 8'd0, 8'd0);
    run_instr(bcrm_pkg::OP_BFS, 8'd0, 8'h00, 8'h30);
    run_instr(bcrm_pkg::OP_STM, 8'hFF, 8'hFF, 8'd0);
    run_instr(bcrm_pkg::OP_LDM, 8'd3, 8'hFF, 8'hFF);
    for (int f = 0; f < 4; f++) run_instr(bcrm_pkg::OP_PUT, f[7:0], f[7:0], 8'd0);
    run_instr(bcrm_pkg::OP_PUT, 8'd1, 8'd7, 8'd0);
    run_instr(bcrm_pkg::OP_JMP, 8'hFA, 8'hFF, 8'd0);
    run_instr(bcrm_pkg::OP_JMP, 8'h00, 8'h00, 8'd0);
    quiet = 1'b0;
  endtask

  task automatic test_random(input int count);
    repeat (count) run_random_instr();
  endtask

  // Several program lengths, a quiet stretch at 65535.
  task automatic test_length_settings();
    set_length(17'd16);
    test_random(8);
    set_length(17'd300);
    test_random(8);
    set_length(17'd65535);
    quiet = 1'b1;
    test_random(6);
    quiet = 1'b0;
    set_length(17'd65536);
    test_random(10);
  endtask

  // Receiver stalls long while the sender keeps offering, then the sender pauses.
  task automatic test_backpressure();
    fork
      begin
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
      test_random(8);
    join
    wait_drained();
    repeat (20) @(posedge clk);
    test_random(8);
  endtask

  // Fetch runs past the program end; afterwards steps change nothing.
  task automatic test_halt();
    set_length(17'd2);
    run_instr(bcrm_pkg::OP_JMP, 8'h34, 8'h12, 8'h00);
    run_instr(bcrm_pkg::OP_LDI, 8'd0, 8'h11, 8'h22);
    send_word(1'b0, 16'($urandom), 8'($urandom));
    set_length(17'd0);
    send_word(1'b1, 16'($urandom), 8'($urandom));
    send_word(1'b0, 16'($urandom), 8'($urandom));
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    rx_hold    = 1'b0;
    quiet      = 1'b0;
    fail_count = 0;
    shadow_pc    = '0;
    shadow_len   = '0;
    shadow_flags = '0;
    shadow_halt  = 1'b0;
    shadow_err   = bcrm_pkg::ERR_NONE;
    for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_loads_at_reset();
    test_each_opcode();
    test_random(6);
    test_length_settings();
    test_backpressure();
    test_halt();

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("byte_code_register_machine_test: PASS");
    end else begin
      $display("byte_code_register_machine_test: FAIL");
    end
    $finish;
  end

endmodule
